[design/sequence_list_table_engine_unit_defines.svh]
// Assertion macros shared by the list engine RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef SEQUENCE_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH
`define SEQUENCE_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SLTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define SLTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/slte_pkg.sv]
// Package for the list engine: field widths, operation and status codes,
// controller state type. No dependencies.
`default_nettype none

package slte_pkg;

  localparam int unsigned ListDepthDef = 64;
  localparam int unsigned OpW          = 3;
  localparam int unsigned ValW         = 32;
  localparam int unsigned StatusW      = 2;

  localparam logic [OpW-1:0] OP_APPEND = 3'd0;
  localparam logic [OpW-1:0] OP_SEARCH = 3'd1;
  localparam logic [OpW-1:0] OP_DELETE = 3'd2;
  localparam logic [OpW-1:0] OP_UPDATE = 3'd3;
  localparam logic [OpW-1:0] OP_DUMP   = 3'd4;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

`default_nettype wire

[design/slte_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module slte_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/sequence_list_table_engine_unit.sv]
// Ordered value list engine: controller and scan datapath around one list RAM.
// Depends on slte_pkg, slte_ram and sequence_list_table_engine_unit_defines.svh.
//
// Use: an item (operation, value, new value) is taken at a rising edge where
// start is high and busy is low. Every result appears on status_o,
// entry_value_o and last_o for exactly one cycle with result_strobe_o high;
// the receiver cannot stall, so each result is taken in the cycle it is shown.
// Append, unknown operations and any operation on an empty list are handled
// in the accept cycle: busy stays low and the single result (if any) follows
// in the next cycle, so such items may be issued back to back.
// Search, update, delete and dump of a non-empty list raise busy and read the
// list RAM one entry per cycle through its single read port. Search and
// update finish at the first match; delete and dump always walk the whole
// list. Dump emits one result per entry, back to back, the last one flagged.
// Each result appears in the cycle after the scan step that produced it.
// Reset clears the entry count and the controller; the RAM contents are not
// cleared, as only entries below the count are ever read.
`default_nettype none
`include "sequence_list_table_engine_unit_defines.svh"

module sequence_list_table_engine_unit #(
  parameter int unsigned LIST_DEPTH = slte_pkg::ListDepthDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [slte_pkg::OpW-1:0]     operation_i,
  input  wire logic signed [slte_pkg::ValW-1:0]    value_i,
  input  wire logic signed [slte_pkg::ValW-1:0]    new_value_i,
  output logic                                     result_strobe_o,
  output logic             [slte_pkg::StatusW-1:0] status_o,
  output logic signed      [slte_pkg::ValW-1:0]    entry_value_o,
  output logic                                     last_o
);

  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned ValW  = slte_pkg::ValW;

  slte_pkg::state_e state_q, state_d;

  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [CntW-1:0]              rd_addr_q, rd_addr_d;
  logic                         rdv_q, rdv_d;
  logic                         found_q, found_d;
  logic [AddrW-1:0]             prev_q, prev_d;
  logic [slte_pkg::OpW-1:0]     op_q, op_d;
  logic [ValW-1:0]              val_q, val_d;
  logic [ValW-1:0]              nv_q, nv_d;
  logic                         strobe_q, strobe_d;
  logic [slte_pkg::StatusW-1:0] status_q, status_d;
  logic [ValW-1:0]              entry_q, entry_d;
  logic                         last_q, last_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ValW-1:0]  ram_wdata;
  logic             ram_re;
  logic [ValW-1:0]  ram_rdata;

  logic accept_w;
  logic scan_op_w;
  logic scan_done_w;
  logic match_w;
  logic at_end_w;

  assign accept_w = start && !busy;
  assign scan_op_w = (operation_i == slte_pkg::OP_SEARCH) ||
                     (operation_i == slte_pkg::OP_DELETE) ||
                     (operation_i == slte_pkg::OP_UPDATE) ||
                     (operation_i == slte_pkg::OP_DUMP);
  assign match_w  = rdv_q && (ram_rdata == val_q);
  assign at_end_w = rdv_q && (CntW'(prev_q) == (cnt_q - CntW'(1)));

  slte_ram #(
    .Width(ValW),
    .Depth(LIST_DEPTH)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_addr_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      slte_pkg::ST_IDLE: begin
        if (accept_w && scan_op_w && (cnt_q != '0)) begin
          state_d = slte_pkg::ST_SCAN;
        end
      end
      slte_pkg::ST_SCAN: begin
        if (scan_done_w) begin
          state_d = slte_pkg::ST_IDLE;
        end
      end
      default: state_d = slte_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM control and results.
  always_comb begin
    cnt_d       = cnt_q;
    rd_addr_d   = rd_addr_q;
    rdv_d       = 1'b0;
    found_d     = found_q;
    prev_d      = prev_q;
    op_d        = op_q;
    val_d       = val_q;
    nv_d        = nv_q;
    strobe_d    = 1'b0;
    status_d    = slte_pkg::STATUS_OK;
    entry_d     = '0;
    last_d      = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[AddrW-1:0];
    ram_wdata   = value_i;
    ram_re      = 1'b0;
    scan_done_w = 1'b0;

    case (state_q)
      slte_pkg::ST_IDLE: begin
        if (accept_w) begin
          op_d      = operation_i;
          val_d     = value_i;
          nv_d      = new_value_i;
          rd_addr_d = '0;
          found_d   = 1'b0;
          case (operation_i)
            slte_pkg::OP_APPEND: begin
              strobe_d = 1'b1;
              if (cnt_q == CntW'(LIST_DEPTH)) begin
                status_d = slte_pkg::STATUS_FULL;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            slte_pkg::OP_SEARCH, slte_pkg::OP_DELETE, slte_pkg::OP_UPDATE,
            slte_pkg::OP_DUMP: begin
              if (cnt_q == '0) begin
                strobe_d = 1'b1;
                status_d = slte_pkg::STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end

      slte_pkg::ST_SCAN: begin
        // One read issued per cycle; its data is compared in the next cycle.
        if (rd_addr_q < cnt_q) begin
          ram_re    = 1'b1;
          rd_addr_d = rd_addr_q + CntW'(1);
          rdv_d     = 1'b1;
          prev_d    = rd_addr_q[AddrW-1:0];
        end
        case (op_q)
          slte_pkg::OP_SEARCH, slte_pkg::OP_UPDATE: begin
            if (match_w) begin
              strobe_d    = 1'b1;
              scan_done_w = 1'b1;
              if (op_q == slte_pkg::OP_UPDATE) begin
                ram_we    = 1'b1;
                ram_waddr = prev_q;
                ram_wdata = nv_q;
              end
            end else if (at_end_w) begin
              strobe_d    = 1'b1;
              status_d    = slte_pkg::STATUS_NOT_FOUND;
              scan_done_w = 1'b1;
            end
          end
          slte_pkg::OP_DELETE: begin
            // Once the victim is found, every later entry moves down one place.
            if (rdv_q && found_q) begin
              ram_we    = 1'b1;
              ram_waddr = prev_q - AddrW'(1);
              ram_wdata = ram_rdata;
            end
            if (match_w) begin
              found_d = 1'b1;
            end
            if (at_end_w) begin
              strobe_d    = 1'b1;
              scan_done_w = 1'b1;
              if (found_q || match_w) begin
                cnt_d = cnt_q - CntW'(1);
              end else begin
                status_d = slte_pkg::STATUS_NOT_FOUND;
              end
            end
          end
          slte_pkg::OP_DUMP: begin
            if (rdv_q) begin
              strobe_d    = 1'b1;
              entry_d     = ram_rdata;
              last_d      = at_end_w;
              scan_done_w = at_end_w;
            end
          end
          default: scan_done_w = 1'b1;
        endcase
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= slte_pkg::ST_IDLE;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      rdv_q     <= 1'b0;
      found_q   <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_addr_q <= rd_addr_d;
      rdv_q     <= rdv_d;
      found_q   <= found_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q   <= prev_d;
    op_q     <= op_d;
    val_q    <= val_d;
    nv_q     <= nv_d;
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign busy            = (state_q == slte_pkg::ST_SCAN);
  assign result_strobe_o = strobe_q;
  assign status_o        = status_q;
  assign entry_value_o   = entry_q;
  assign last_o          = last_q;

  `SLTE_ASSERT(a_cnt_in_range, cnt_q <= CntW'(LIST_DEPTH), "entry count beyond list depth")
  `SLTE_ASSERT(a_write_in_list, !ram_we || (CntW'(ram_waddr) < cnt_q) || (!busy && CntW'(ram_waddr) == cnt_q), "RAM write outside the list")
  `SLTE_ASSERT_NEXT(a_strobe_cause, !accept_w && !busy, !result_strobe_o, "result with no item in progress")
  `SLTE_ASSERT(a_cnt_step, $stable(cnt_q) || (cnt_q == CntW'($past(cnt_q) + CntW'(1))) || (cnt_q == CntW'($past(cnt_q) - CntW'(1))), "entry count moved by more than one")

endmodule

`default_nettype wire

[sim/tb_sequence_list_table_engine_unit.sv]
// Self-checking testbench for sequence_list_table_engine_unit: a shadow list predicts
// every result, which a monitor checks field by field. Depends on slte_pkg and the RTL.
module tb_sequence_list_table_engine_unit;

  localparam int unsigned LIST_DEPTH = slte_pkg::ListDepthDef;
  localparam int unsigned OpW = slte_pkg::OpW;
  localparam int unsigned ValW = slte_pkg::ValW;
  localparam int unsigned StatusW = slte_pkg::StatusW;
  localparam int unsigned OP_CODE_MAX = (1 << OpW) - 1;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic        [OpW-1:0]  op;
    logic signed [ValW-1:0] value;
    logic signed [ValW-1:0] new_value;
    bit                     drain_first;
  } list_cmd_t;

  typedef struct {
    logic        [StatusW-1:0] status;
    logic signed [ValW-1:0]    entry_value;
    logic                      last;
  } list_result_t;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic        [OpW-1:0]     operation_i = '0;
  logic signed [ValW-1:0]    value_i = '0;
  logic signed [ValW-1:0]    new_value_i = '0;
  logic                      result_strobe_o;
  logic        [StatusW-1:0] status_o;
  logic signed [ValW-1:0]    entry_value_o;
  logic                      last_o;

  sequence_list_table_engine_unit #(
    .LIST_DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .new_value_i    (new_value_i),
    .result_strobe_o(result_strobe_o),
    .status_o       (status_o),
    .entry_value_o  (entry_value_o),
    .last_o         (last_o)
  );

  // Shadow copy of the list and the results still owed by the block.
  logic signed [ValW-1:0] shadow_vals [LIST_DEPTH];
  int unsigned            shadow_len = 0;
  list_result_t           owed_results[$];
  list_cmd_t              pending_cmds[$];
  logic signed [ValW-1:0] value_pool[16];

  int unsigned op_seen[OP_CODE_MAX+1];
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned longest_list = 0;
  int unsigned refused_full = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d items pending and %0d results owed",
             pending_cmds.size(), owed_results.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic predict_list_op(input list_cmd_t c);
    int hit;
    list_result_t r;
    bit single;
    hit = -1;
    single = 1'b1;
    r.status = slte_pkg::STATUS_OK;
    r.entry_value = '0;
    r.last = 1'b1;
    for (int i = 0; i < shadow_len; i++)
      if (hit < 0 && shadow_vals[i] == c.value) hit = i;
    case (c.op)
      slte_pkg::OP_APPEND: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.status = slte_pkg::STATUS_FULL;
          refused_full++;
        end else begin
          shadow_vals[shadow_len] = c.value;
          shadow_len++;
          if (shadow_len > longest_list) longest_list = shadow_len;
        end
      end
      slte_pkg::OP_SEARCH: begin
        if (shadow_len == 0) r.status = slte_pkg::STATUS_EMPTY;
        else if (hit < 0) r.status = slte_pkg::STATUS_NOT_FOUND;
      end
      slte_pkg::OP_DELETE: begin
        if (shadow_len == 0) r.status = slte_pkg::STATUS_EMPTY;
        else if (hit < 0) r.status = slte_pkg::STATUS_NOT_FOUND;
        else begin
          for (int i = hit; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
        end
      end
      slte_pkg::OP_UPDATE: begin
        if (shadow_len == 0) r.status = slte_pkg::STATUS_EMPTY;
        else if (hit < 0) r.status = slte_pkg::STATUS_NOT_FOUND;
        else shadow_vals[hit] = c.new_value;
      end
      slte_pkg::OP_DUMP: begin
        if (shadow_len == 0) r.status = slte_pkg::STATUS_EMPTY;
        else begin
          single = 1'b0;
          for (int i = 0; i < shadow_len; i++) begin
            r.entry_value = shadow_vals[i];
            r.last = (i + 1 == shadow_len);
            owed_results.push_back(r);
          end
        end
      end
      // Unused operation codes leave the list alone and owe nothing.
      default: single = 1'b0;
    endcase
    if (single) owed_results.push_back(r);
  endtask

  function automatic logic signed [ValW-1:0] pick_value();
    if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  function automatic list_cmd_t make_cmd(input logic [OpW-1:0] op,
                                         input logic signed [ValW-1:0] value,
                                         input logic signed [ValW-1:0] new_value);
    list_cmd_t c;
    c.op = op;
    c.value = value;
    c.new_value = new_value;
    c.drain_first = 1'b0;
    return c;
  endfunction

  // Driver: an item is taken when start is high and busy is low at the edge.
  always @(posedge clk_i) begin
    list_cmd_t c;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_list_op(make_cmd(operation_i, value_i, new_value_i));
        op_seen[operation_i]++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].drain_first && owed_results.size() != 0) begin
          start <= 1'b0;
        end else begin
          c = pending_cmds.pop_front();
          operation_i <= c.op;
          value_i <= c.value;
          new_value_i <= c.new_value;
          start <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest owed result.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && result_strobe_o) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: status %0d entry %0d last %0b",
                   status_o, entry_value_o, last_o);
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (status_o !== want.status || entry_value_o !== want.entry_value ||
            last_o !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch on result %0d: expected status %0d entry %0d last %0b,%s",
                     results_checked, want.status, want.entry_value, want.last,
                     $sformatf(" got status %0d entry %0d last %0b",
                               status_o, entry_value_o, last_o));
        end
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned seg;
    int unsigned seg_len;
    int unsigned pick;
    int unsigned unused_seen;
    list_cmd_t c;
    counted = 0;
    seg = 0;
    unused_seen = 0;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -1;

    // Directed part: empty list answers, extremes, duplicates and unused codes.
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DUMP, 0, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_SEARCH, 1, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DELETE, 1, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_UPDATE, 1, 2));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_APPEND, 32'sh8000_0000, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_APPEND, 32'sh7fff_ffff, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_APPEND, 0, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_APPEND, -1, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_APPEND, 32'sh7fff_ffff, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_APPEND, 5, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_SEARCH, 32'sh7fff_ffff, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_SEARCH, 12345, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_UPDATE, 32'sh7fff_ffff, 32'shaaaa_aaaa));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_UPDATE, 999, 32'sh5555_5555));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DUMP, 0, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DELETE, 32'sh7fff_ffff, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DELETE, 32'sh8000_0000, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DELETE, 5, 0));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DELETE, 777, 0));
    for (int unsigned k = slte_pkg::OP_DUMP + 1; k <= OP_CODE_MAX; k++)
      pending_cmds.push_back(make_cmd(OpW'(k), $urandom, $urandom));
    pending_cmds.push_back(make_cmd(slte_pkg::OP_DUMP, 0, 0));

    // Random part: mixed traffic, a fill past the capacity, then a drain.
    while (counted < 210) begin
      case (seg % 4)
        1: begin
          for (int k = 0; k < LIST_DEPTH + 2; k++) begin
            c = make_cmd(slte_pkg::OP_APPEND, pick_value(), 0);
            c.drain_first = (k == 0);
            pending_cmds.push_back(c);
          end
          pending_cmds.push_back(make_cmd(slte_pkg::OP_DUMP, 0, 0));
          counted += LIST_DEPTH + 3;
        end
        3: begin
          seg_len = $urandom_range(30, 45);
          for (int k = 0; k < seg_len; k++) begin
            pick = $urandom_range(0, 4);
            c = make_cmd((pick == 0) ? slte_pkg::OP_SEARCH : slte_pkg::OP_DELETE,
                         pick_value(), $urandom);
            pending_cmds.push_back(c);
          end
          pending_cmds.push_back(make_cmd(slte_pkg::OP_DUMP, 0, 0));
          counted += seg_len + 1;
        end
        default: begin
          seg_len = $urandom_range(30, 50);
          for (int k = 0; k < seg_len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) c = make_cmd(slte_pkg::OP_APPEND, pick_value(), $urandom);
            else if (pick < 50) c = make_cmd(slte_pkg::OP_SEARCH, pick_value(), $urandom);
            else if (pick < 70) c = make_cmd(slte_pkg::OP_DELETE, pick_value(), $urandom);
            else if (pick < 85) c = make_cmd(slte_pkg::OP_UPDATE, pick_value(), pick_value());
            else if (pick < 95) c = make_cmd(slte_pkg::OP_DUMP, $urandom, $urandom);
            else c = make_cmd(OpW'($urandom_range(slte_pkg::OP_DUMP + 1, OP_CODE_MAX)),
                              $urandom, $urandom);
            pending_cmds.push_back(c);
            if (pick < 95) counted++;
          end
        end
      endcase
      seg++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 8) @(posedge clk_i);

    for (int unsigned k = slte_pkg::OP_DUMP + 1; k <= OP_CODE_MAX; k++)
      unused_seen += op_seen[k];
    $display("Run covered %0d append, %0d search, %0d delete, %0d update, %0d dump items%s",
             op_seen[slte_pkg::OP_APPEND], op_seen[slte_pkg::OP_SEARCH],
             op_seen[slte_pkg::OP_DELETE], op_seen[slte_pkg::OP_UPDATE],
             op_seen[slte_pkg::OP_DUMP],
             $sformatf(" and %0d with unused codes.", unused_seen));
    $display("%0d results checked, longest list %0d, %0d appends refused as full, %0d %s",
             results_checked, longest_list, refused_full, mismatches, "mismatches.");
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sequence_list_table_engine_unit.f]
+incdir+design
design/slte_pkg.sv
design/slte_ram.sv
design/sequence_list_table_engine_unit.sv
sim/tb_sequence_list_table_engine_unit.sv
